>>> hdl/csvt_pkg.sv
// Shared types and constants for the CSV field tokenizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csvt_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LB = 8'd1;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd44;

	// Quote tracking codes
	localparam logic [1:0] QS_UNQUOTED = 2'd0;
	localparam logic [1:0] QS_INSIDE   = 2'd1;
	localparam logic [1:0] QS_AFTER    = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] delimiter;
		logic              replace_line_breaks;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              end_of_data;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              field_end;
		logic              row_end;
	} result_t;

endpackage
`default_nettype wire

>>> hdl/csvt_text_if.sv
// Input channel: one CSV text byte or end-of-data mark per word.
// Depends on csvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface csvt_text_if;
	logic                      valid;
	logic                      ready;
	logic [csvt_pkg::BYTE_W-1:0] in_byte;
	logic                      end_of_data;

	modport source(output valid, output in_byte, output end_of_data, input ready);
	modport sink(input valid, input in_byte, input end_of_data, output ready);
endinterface
`default_nettype wire

>>> hdl/csvt_token_if.sv
// Output channel: one token word (content byte or field/row end mark).
// Depends on csvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface csvt_token_if;
	logic                      valid;
	logic                      ready;
	logic [csvt_pkg::BYTE_W-1:0] out_byte;
	logic                      byte_valid;
	logic                      field_end;
	logic                      row_end;

	modport source(output valid, output out_byte, output byte_valid, output field_end,
		output row_end, input ready);
	modport sink(input valid, input out_byte, input byte_valid, input field_end,
		input row_end, output ready);
endinterface
`default_nettype wire

>>> hdl/csvt_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on csvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface csvt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [csvt_pkg::CFG_IDX_W-1:0]  index;
	logic [csvt_pkg::CFG_DATA_W-1:0] wdata;

	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

>>> hdl/csvt_cfg_regs.sv
// Configuration registers: delimiter and line break replacement mode.
// Depends on csvt_pkg and csvt_cfg_if.
`timescale 1ns / 1ps
`default_nettype none
module csvt_cfg_regs (
	input  wire logic    clk,
	input  wire logic    arst_n,
	csvt_cfg_if.sink     cfg,
	output csvt_pkg::cfg_t cfg_out
);
	csvt_pkg::cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_out   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter           <= csvt_pkg::DELIM_RESET;
			cfg_q.replace_line_breaks <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				csvt_pkg::CFG_DELIMITER: begin
					cfg_q.delimiter <= cfg.wdata;
				end
				csvt_pkg::CFG_REPLACE_LB: begin
					cfg_q.replace_line_breaks <= cfg.wdata[0];
				end
				default: begin
					// unknown index: ignored
				end
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hdl/csvt_core.sv
// Tokenizer state and per-byte decision logic.
// Depends on csvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csvt_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step_en,
	input  wire csvt_pkg::item_t item,
	input  wire csvt_pkg::cfg_t  cfg,
	output logic                 res_valid,
	output csvt_pkg::result_t    res
);
	logic [1:0] qs_q, qs_d;
	logic       skip_lf_q, skip_lf_d;
	logic       fhb_q, fhb_d;      // field has bytes
	logic       rhf_q, rhf_d;      // row has fields
	logic       cr_pend_q, cr_pend_d;

	logic                          unq;
	logic                          do_append;
	logic [csvt_pkg::BYTE_W-1:0]   app_byte;
	logic                          do_end;
	logic                          end_row;
	logic [csvt_pkg::BYTE_W-1:0]   b;

	always_comb begin
		b         = item.in_byte;
		qs_d      = qs_q;
		skip_lf_d = skip_lf_q;
		fhb_d     = fhb_q;
		rhf_d     = rhf_q;
		cr_pend_d = cr_pend_q;
		res_valid = 1'b0;
		res       = '0;
		unq       = 1'b0;
		do_append = 1'b0;
		app_byte  = b;
		do_end    = 1'b0;
		end_row   = 1'b0;

		if (item.end_of_data) begin
			res_valid     = fhb_q | rhf_q;
			res.field_end = 1'b1;
			res.row_end   = 1'b1;
			qs_d          = csvt_pkg::QS_UNQUOTED;
			fhb_d         = 1'b0;
			rhf_d         = 1'b0;
			cr_pend_d     = 1'b0;
		end else begin
			case (qs_q)
				csvt_pkg::QS_AFTER: begin
					if (b == csvt_pkg::CH_QUOTE) begin
						// doubled quote: literal quote
						qs_d      = csvt_pkg::QS_INSIDE;
						do_append = 1'b1;
					end else begin
						skip_lf_d = 1'b0;
						qs_d      = csvt_pkg::QS_UNQUOTED;
						unq       = 1'b1;
					end
				end
				csvt_pkg::QS_INSIDE: begin
					if (b == csvt_pkg::CH_QUOTE)
						qs_d = csvt_pkg::QS_AFTER;
					else
						do_append = 1'b1;
				end
				default: begin
					qs_d = csvt_pkg::QS_UNQUOTED;
					unq  = 1'b1;
				end
			endcase

			if (unq) begin
				if (b == csvt_pkg::CH_QUOTE) begin
					qs_d = csvt_pkg::QS_INSIDE;
				end else if (b == csvt_pkg::CH_CR) begin
					skip_lf_d = 1'b1;
					do_end    = 1'b1;
					end_row   = 1'b1;
				end else if (b == csvt_pkg::CH_LF) begin
					if (skip_lf_d) begin
						skip_lf_d = 1'b0;
					end else begin
						do_end  = 1'b1;
						end_row = 1'b1;
					end
				end else begin
					skip_lf_d = 1'b0;
					if (b == cfg.delimiter)
						do_end = 1'b1;
					else
						do_append = 1'b1;
				end
			end

			if (do_append) begin
				if (cfg.replace_line_breaks &&
						(app_byte == csvt_pkg::CH_CR || app_byte == csvt_pkg::CH_LF)) begin
					if (app_byte == csvt_pkg::CH_LF && cr_pend_q) begin
						// LF of a replaced CRLF: dropped
						cr_pend_d = 1'b0;
					end else begin
						cr_pend_d      = (app_byte == csvt_pkg::CH_CR);
						fhb_d          = 1'b1;
						res_valid      = 1'b1;
						res.out_byte   = csvt_pkg::CH_SPACE;
						res.byte_valid = 1'b1;
					end
				end else begin
					cr_pend_d      = 1'b0;
					fhb_d          = 1'b1;
					res_valid      = 1'b1;
					res.out_byte   = app_byte;
					res.byte_valid = 1'b1;
				end
			end

			if (do_end) begin
				fhb_d         = 1'b0;
				cr_pend_d     = 1'b0;
				rhf_d         = ~end_row;
				res_valid     = 1'b1;
				res.field_end = 1'b1;
				res.row_end   = end_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qs_q      <= csvt_pkg::QS_UNQUOTED;
			skip_lf_q <= 1'b0;
			fhb_q     <= 1'b0;
			rhf_q     <= 1'b0;
			cr_pend_q <= 1'b0;
		end else if (step_en) begin
			qs_q      <= qs_d;
			skip_lf_q <= skip_lf_d;
			fhb_q     <= fhb_d;
			rhf_q     <= rhf_d;
			cr_pend_q <= cr_pend_d;
		end
	end
endmodule
`default_nettype wire

>>> hdl/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer: input register, core, result register.
// Depends on csvt_pkg, csvt_text_if, csvt_token_if, csvt_cfg_if, csvt_cfg_regs,
// csvt_core.
//
//   channel | dir | words                                  | handshake
//   text    | in  | in_byte, end_of_data                   | valid/ready
//   token   | out | out_byte, byte_valid, field_end, row_end | valid/ready
//   cfg     | in  | index, wdata                           | valid/ready (ready tied high)
//
// Flow: one text word per clock while token.ready is high. A word is first
// registered in the input register; the core then decides from it and updates
// its state while the result (if any) is loaded into the token register.
// Words that produce no token (opening or closing quote, swallowed LF, dropped LF
// of a replaced CRLF, empty end of data) simply retire from the input register.
// Reset: arst_n clears quote state, row/field flags, valid bits; delimiter
// returns to ',' and line break replacement is off.
// Stalls: token.ready low holds the token register; the input register then
// holds only if its word has a token to give, and text.ready falls with it.
`timescale 1ns / 1ps
`default_nettype none
module csv_field_tokenizer (
	input  wire logic     clk,
	input  wire logic     arst_n,
	csvt_text_if.sink     text,
	csvt_token_if.source  token,
	csvt_cfg_if.sink      cfg
);
	csvt_pkg::cfg_t    cfg_cur;
	csvt_pkg::item_t   item_s1;
	logic              valid_s1;
	logic              res_valid;
	csvt_pkg::result_t res;
	csvt_pkg::result_t out_q;
	logic              out_valid_q;
	logic              out_free;
	logic              move_s1;
	logic              load_s1;

	csvt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_cur)
	);

	// Token register can take a new word when empty or being drained.
	assign out_free = ~out_valid_q | token.ready;
	// Input word retires when it has nothing to emit or the token register is free.
	assign move_s1  = valid_s1 & (~res_valid | out_free);
	assign text.ready = ~valid_s1 | move_s1;
	assign load_s1  = text.valid & text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (text.ready)
			valid_s1 <= text.valid;
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.in_byte     <= text.in_byte;
			item_s1.end_of_data <= text.end_of_data;
		end
	end

	csvt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (move_s1),
		.item      (item_s1),
		.cfg       (cfg_cur),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= move_s1 & res_valid;
	end

	always_ff @(posedge clk) begin
		if (out_free && move_s1 && res_valid)
			out_q <= res;
	end

	assign token.valid      = out_valid_q;
	assign token.out_byte   = out_q.out_byte;
	assign token.byte_valid = out_q.byte_valid;
	assign token.field_end  = out_q.field_end;
	assign token.row_end    = out_q.row_end;
endmodule
`default_nettype wire
